// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FSQ_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FSQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/fsq_pkg.sv -----
package fsq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    typedef enum logic [1:0] {
        PH_OUTER,
        PH_INNER,
        PH_PAIR,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SRCH,
        S_O_CUR,
        S_O_CHK,
        S_I_CUR,
        S_I_CHK,
        S_P_HI,
        S_P_SUM,
        S_P_DEC,
        S_L_CHK,
        S_L_CMP,
        S_H_CHK,
        S_H_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                          we;
        logic [IDX_W-1:0]              waddr;
        logic signed [VALUE_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]              raddr;
    } mem_req_t;

    typedef struct packed {
        logic                          found;
        logic signed [VALUE_WIDTH-1:0] first;
        logic signed [VALUE_WIDTH-1:0] second;
        logic signed [VALUE_WIDTH-1:0] third;
        logic signed [VALUE_WIDTH-1:0] fourth;
        logic                          done_res;
        logic                          overflowed;
    } result_t;

endpackage

// ----- rtl/fsq_in_if.sv -----
interface fsq_in_if;
    import fsq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

// ----- rtl/fsq_out_if.sv -----
interface fsq_out_if;
    import fsq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          found;
    logic signed [VALUE_WIDTH-1:0] first;
    logic signed [VALUE_WIDTH-1:0] second;
    logic signed [VALUE_WIDTH-1:0] third;
    logic signed [VALUE_WIDTH-1:0] fourth;
    logic                          done_res;
    logic                          overflowed;

    modport source (output valid, output found, output first, output second, output third,
                    output fourth, output done_res, output overflowed, input ready);
    modport sink (input valid, input found, input first, input second, input third,
                  input fourth, input done_res, input overflowed, output ready);
endinterface

// ----- rtl/fsq_store.sv -----
module fsq_store (
    input  logic                                  clk,
    input  fsq_pkg::mem_req_t                     req,
    output logic signed [fsq_pkg::VALUE_WIDTH-1:0] rdata
);
    import fsq_pkg::*;

    logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

// ----- rtl/fsq_ctrl.sv -----
module fsq_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             operation,
    input  logic signed [fsq_pkg::VALUE_WIDTH-1:0] value,
    input  logic signed [fsq_pkg::VALUE_WIDTH-1:0] target,
    input  logic                                   out_busy,
    output logic                                   emit,
    output fsq_pkg::result_t                       res,
    output fsq_pkg::mem_req_t                      mreq,
    input  logic signed [fsq_pkg::VALUE_WIDTH-1:0] rdata
);
    import fsq_pkg::*;

    localparam int SUM_W = VALUE_WIDTH + 2;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] outer_reg, outer_next;
    logic [IDX_W-1:0] second_reg, second_next;
    logic [IDX_W-1:0] low_reg, low_next;
    logic [IDX_W-1:0] high_reg, high_next;
    logic [IDX_W-1:0] ins_reg, ins_next;
    logic             ovf_reg, ovf_next;

    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic signed [VALUE_WIDTH-1:0] tmp_reg, tmp_next;
    logic signed [VALUE_WIDTH-1:0] a_reg, a_next;
    logic signed [VALUE_WIDTH-1:0] b_reg, b_next;
    logic signed [VALUE_WIDTH-1:0] lo_reg, lo_next;
    logic signed [VALUE_WIDTH-1:0] hi_reg, hi_next;
    logic signed [VALUE_WIDTH:0]   ab_reg, ab_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;

    logic [CNT_W:0]          outer_w, second_w, low_w, n_w;
    logic signed [SUM_W-1:0] target_w;

    assign outer_w  = {2'b0, outer_reg};
    assign second_w = {2'b0, second_reg};
    assign low_w    = {2'b0, low_reg};
    assign n_w      = {1'b0, count_reg};
    assign target_w = SUM_W'(target);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_OUTER;
            count_reg  <= '0;
            outer_reg  <= '0;
            second_reg <= IDX_W'(1);
            low_reg    <= '0;
            high_reg   <= '0;
            ins_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            outer_reg  <= outer_next;
            second_reg <= second_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            ins_reg    <= ins_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        tmp_reg <= tmp_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ab_reg  <= ab_next;
        sum_reg <= sum_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        outer_next  = outer_reg;
        second_next = second_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        ins_next    = ins_reg;
        ovf_next    = ovf_reg;
        val_next    = val_reg;
        tmp_next    = tmp_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ab_next     = ab_reg;
        sum_next    = sum_reg;
        in_ready    = 1'b0;
        emit        = 1'b0;
        res         = '0;
        res.overflowed = ovf_reg;
        mreq        = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = !out_busy;
                if (in_valid && !out_busy)
                begin
                    if (operation == OP_CLEAR || operation == OP_LOAD)
                    begin
                        phase_next  = PH_OUTER;
                        outer_next  = '0;
                        second_next = IDX_W'(1);
                        low_next    = '0;
                        high_next   = '0;
                    end
                    if (operation == OP_CLEAR)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else if (operation == OP_LOAD)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            val_next   = value;
                            ins_next   = count_reg[IDX_W-1:0];
                            state_next = S_INS_RD;
                        end
                    end
                    else if (operation == OP_FETCH)
                    begin
                        state_next = S_SRCH;
                    end
                end
            end

            // shift larger entries up one slot, from the top down
            S_INS_RD:
            begin
                if (ins_reg == '0)
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = ins_reg;
                    mreq.wdata = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    mreq.raddr = ins_reg - IDX_W'(1);
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = ins_reg;
                if (rdata > val_reg)
                begin
                    mreq.wdata = rdata;
                    ins_next   = ins_reg - IDX_W'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    mreq.wdata = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_SRCH:
            begin
                case (phase_reg)
                    PH_DONE:
                    begin
                        emit         = 1'b1;
                        res.done_res = 1'b1;
                        state_next   = S_IDLE;
                    end
                    PH_OUTER:
                    begin
                        if (outer_w + (CNT_W+1)'(3) >= n_w)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (outer_reg != '0)
                        begin
                            mreq.raddr = outer_reg - IDX_W'(1);
                            state_next = S_O_CUR;
                        end
                        else
                        begin
                            mreq.raddr = outer_reg;
                            state_next = S_O_CHK;
                        end
                    end
                    PH_INNER:
                    begin
                        if (second_w + (CNT_W+1)'(2) >= n_w)
                        begin
                            outer_next = outer_reg + IDX_W'(1);
                            phase_next = PH_OUTER;
                        end
                        else if (second_w > outer_w + (CNT_W+1)'(1))
                        begin
                            mreq.raddr = second_reg - IDX_W'(1);
                            state_next = S_I_CUR;
                        end
                        else
                        begin
                            mreq.raddr = second_reg;
                            state_next = S_I_CHK;
                        end
                    end
                    PH_PAIR:
                    begin
                        if (low_reg >= high_reg)
                        begin
                            second_next = second_reg + IDX_W'(1);
                            phase_next  = PH_INNER;
                        end
                        else
                        begin
                            mreq.raddr = low_reg;
                            state_next = S_P_HI;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end

            S_O_CUR:
            begin
                tmp_next   = rdata;
                mreq.raddr = outer_reg;
                state_next = S_O_CHK;
            end

            S_O_CHK:
            begin
                if (outer_reg != '0 && rdata == tmp_reg)
                begin
                    outer_next = outer_reg + IDX_W'(1);
                end
                else
                begin
                    a_next      = rdata;
                    second_next = outer_reg + IDX_W'(1);
                    phase_next  = PH_INNER;
                end
                state_next = S_SRCH;
            end

            S_I_CUR:
            begin
                tmp_next   = rdata;
                mreq.raddr = second_reg;
                state_next = S_I_CHK;
            end

            S_I_CHK:
            begin
                if (second_w > outer_w + (CNT_W+1)'(1) && rdata == tmp_reg)
                begin
                    second_next = second_reg + IDX_W'(1);
                end
                else
                begin
                    b_next     = rdata;
                    ab_next    = (VALUE_WIDTH+1)'(a_reg) + (VALUE_WIDTH+1)'(rdata);
                    low_next   = second_reg + IDX_W'(1);
                    high_next  = IDX_W'(count_reg - CNT_W'(1));
                    phase_next = PH_PAIR;
                end
                state_next = S_SRCH;
            end

            S_P_HI:
            begin
                lo_next    = rdata;
                mreq.raddr = high_reg;
                state_next = S_P_SUM;
            end

            S_P_SUM:
            begin
                hi_next    = rdata;
                sum_next   = SUM_W'(ab_reg) + SUM_W'(lo_reg) + SUM_W'(rdata);
                state_next = S_P_DEC;
            end

            S_P_DEC:
            begin
                if (sum_reg == target_w)
                begin
                    state_next = S_L_CHK;
                end
                else
                begin
                    if (sum_reg > target_w)
                    begin
                        high_next = high_reg - IDX_W'(1);
                    end
                    else
                    begin
                        low_next = low_reg + IDX_W'(1);
                    end
                    state_next = S_SRCH;
                end
            end

            // step past equal values after a hit
            S_L_CHK:
            begin
                if (low_w + (CNT_W+1)'(2) < n_w)
                begin
                    mreq.raddr = low_reg + IDX_W'(1);
                    state_next = S_L_CMP;
                end
                else
                begin
                    state_next = S_H_CHK;
                end
            end

            S_L_CMP:
            begin
                if (rdata == lo_reg)
                begin
                    low_next   = low_reg + IDX_W'(1);
                    state_next = S_L_CHK;
                end
                else
                begin
                    state_next = S_H_CHK;
                end
            end

            S_H_CHK:
            begin
                if (high_reg > second_reg)
                begin
                    mreq.raddr = high_reg - IDX_W'(1);
                    state_next = S_H_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_H_CMP:
            begin
                if (rdata == hi_reg)
                begin
                    high_next  = high_reg - IDX_W'(1);
                    state_next = S_H_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                low_next   = low_reg + IDX_W'(1);
                high_next  = high_reg - IDX_W'(1);
                emit       = 1'b1;
                res.found  = 1'b1;
                res.first  = a_reg;
                res.second = b_reg;
                res.third  = lo_reg;
                res.fourth = hi_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/four_sum_quadruple_search.sv -----
// Four-sum search over a sorted store of up to 64 signed 32-bit values. A load inserts
// its value in order by walking the store from the top down, shifting each entry
// greater than the value up one slot; a clear empties the store. A fetch resumes the
// distinct-quadruple search where the last one left off and returns one transfer: the
// next quadruple whose sum equals the target set via cfg_wdata, or a done mark.
// Each pointer step and each index step reads through the single read port of the
// store, so the length of a fetch is set by how far the walk goes before the next hit.
// No new item is taken until the current one finishes and any pending result is taken.
`include "assert_macros.svh"

module four_sum_quadruple_search (
    input  logic                                   clk,
    input  logic                                   rst_n,
    fsq_in_if.sink                                 in_ch,
    fsq_out_if.source                              out_ch,
    input  logic                                   cfg_we,
    input  logic signed [fsq_pkg::VALUE_WIDTH-1:0] cfg_wdata
);
    import fsq_pkg::*;

    logic signed [VALUE_WIDTH-1:0] target_reg;
    logic                          out_valid_reg;
    result_t                       res_reg;
    logic                          emit;
    result_t                       res;
    mem_req_t                      mreq;
    logic signed [VALUE_WIDTH-1:0] rdata;

    fsq_store u_store (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    fsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .operation (in_ch.operation),
        .value     (in_ch.value),
        .target    (target_reg),
        .out_busy  (out_valid_reg),
        .emit      (emit),
        .res       (res),
        .mreq      (mreq),
        .rdata     (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.found      = res_reg.found;
    assign out_ch.first      = res_reg.first;
    assign out_ch.second     = res_reg.second;
    assign out_ch.third      = res_reg.third;
    assign out_ch.fourth     = res_reg.fourth;
    assign out_ch.done_res   = res_reg.done_res;
    assign out_ch.overflowed = res_reg.overflowed;

    `FSQ_ASSERT_NOW(a_found_not_done, out_ch.valid && out_ch.found, !out_ch.done_res,
        "found result also marked done")
    `FSQ_ASSERT_NOW(a_empty_quad, out_ch.valid && !out_ch.found,
        out_ch.first == '0 && out_ch.fourth == '0, "done result carries data")
    `FSQ_ASSERT_NOW(a_ready_out_free, in_ch.ready, !out_ch.valid,
        "input ready while a result is pending")
    `FSQ_ASSERT_NEXT(a_fetch_busy,
        in_ch.valid && in_ch.ready && in_ch.operation == OP_FETCH, !in_ch.ready,
        "ready right after a fetch transfer")
endmodule
